FILE: design/aqc_pkg.sv
// Shared types, field widths, codes and default sizes for the admission queue controller.
package aqc_pkg;

	// Fixed field widths of the item channels and the configuration register.
	localparam int OP_W       = 2;
	localparam int ID_FIELD_W = 16;
	localparam int OUTCOME_W  = 3;
	localparam int COUNT_W    = 5;
	localparam int CFG_W      = 5;

	// Default sizes handed to the top-level parameters.
	localparam int AQC_QUEUE_DEPTH  = 16;
	localparam int AQC_ACTIVE_SLOTS = 16;
	localparam int AQC_ID_BITS      = 16;

	localparam logic [CFG_W-1:0] MAX_ACTIVE_RESET = CFG_W'(4);

	// Operation codes of an input item.
	typedef enum logic [OP_W-1:0] {
		OP_EXECUTE = 2'd0,
		OP_FINISH  = 2'd1,
		OP_STOP    = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	// Outcome codes of a result item.
	typedef enum logic [OUTCOME_W-1:0] {
		OUT_GRANTED    = 3'd0,
		OUT_QUEUED     = 3'd1,
		OUT_REFUSED    = 3'd2,
		OUT_RELEASED   = 3'd3,
		OUT_UNKNOWN    = 3'd4,
		OUT_STOP_TAKEN = 3'd5,
		OUT_IGNORED    = 3'd6,
		OUT_QUEUE_FULL = 3'd7
	} outcome_t;

	// Priority chain passed from one slot cell to the next.
	typedef struct packed {
		logic match_taken;
		logic free_taken;
	} slot_chain_t;

	// Commands broadcast to every slot cell.
	typedef struct packed {
		logic release_en;
		logic grant_en;
	} slot_ctrl_t;

endpackage

FILE: design/aqc_req_if.sv
// Request channel: operation and requester id with a valid/ready handshake.
interface aqc_req_if import aqc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [ID_FIELD_W-1:0] requester_id;

	modport source (output valid, output operation, output requester_id, input ready);
	modport sink (input valid, input operation, input requester_id, output ready);
endinterface

FILE: design/aqc_rsp_if.sv
// Result channel: outcome, grant and counters with a valid/ready handshake.
interface aqc_rsp_if import aqc_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [OUTCOME_W-1:0]  outcome;
	logic                  grant_valid;
	logic [ID_FIELD_W-1:0] grant_id;
	logic                  halted;
	logic [COUNT_W-1:0]    active_count;
	logic [COUNT_W-1:0]    waiting_count;

	modport source (
		output valid, output outcome, output grant_valid, output grant_id,
		output halted, output active_count, output waiting_count, input ready
	);
	modport sink (
		input valid, input outcome, input grant_valid, input grant_id,
		input halted, input active_count, input waiting_count, output ready
	);
endinterface

FILE: design/aqc_slot_cell.sv
// One entry of the active table: holds a running id and takes part in the search chains.
module aqc_slot_cell import aqc_pkg::*; #(
	parameter int IDW = AQC_ID_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  slot_ctrl_t     ctrl,
	input  logic [IDW-1:0] key_id,
	input  logic [IDW-1:0] grant_id,
	input  slot_chain_t    chain_in,
	output slot_chain_t    chain_out,
	output logic           valid
);

	logic           valid_q;
	logic [IDW-1:0] id_q;
	logic           match_here;
	logic           release_hit;
	logic           free_here;
	logic           grant_hit;

	// The first matching cell in the row releases; the first free cell takes a grant.
	assign match_here  = valid_q && (id_q == key_id);
	assign release_hit = ctrl.release_en && match_here && !chain_in.match_taken;
	assign free_here   = !valid_q || release_hit;
	assign grant_hit   = ctrl.grant_en && free_here && !chain_in.free_taken;

	assign chain_out.match_taken = chain_in.match_taken || match_here;
	assign chain_out.free_taken  = chain_in.free_taken || free_here;
	assign valid                 = valid_q;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (grant_hit) begin
			valid_q <= 1'b1;
		end else if (release_hit) begin
			valid_q <= 1'b0;
		end
	end

	// Stored id, meaningful only while the slot is occupied.
	always_ff @(posedge clk) begin
		if (grant_hit) begin
			id_q <= grant_id;
		end
	end

endmodule

FILE: design/aqc_wait_queue.sv
// Circular FIFO of waiting requester ids with a registered head read.
module aqc_wait_queue import aqc_pkg::*; #(
	parameter int DEPTH = AQC_QUEUE_DEPTH,
	parameter int IDW   = AQC_ID_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [IDW-1:0]             push_data,
	input  logic                       pop,
	output logic [$clog2(DEPTH+1)-1:0] fill,
	output logic [IDW-1:0]             head_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [IDW-1:0]   mem_q [DEPTH];
	logic [IDW-1:0]   rd_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;
	logic [SUM_W-1:0] tail_sum;
	logic [PTR_W-1:0] tail;

	// Tail slot is head plus fill, wrapped once.
	always_comb begin
		tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
		if (tail_sum >= SUM_W'(DEPTH)) begin
			tail = PTR_W'(tail_sum - SUM_W'(DEPTH));
		end else begin
			tail = PTR_W'(tail_sum);
		end
	end

	// Storage with one write port and a registered read of the head slot.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail] <= push_data;
		end
		rd_q <= mem_q[head_q];
	end

	// Head pointer and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (pop) begin
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			fill_q <= fill_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign fill      = fill_q;
	assign head_data = rd_q;

endmodule

FILE: design/admission_queue_controller.sv
// Top level of the admission queue controller: sequencer, counters and slot cell row.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------------------
//   req      | in        | valid/ready        | operation, requester_id
//   rsp      | out       | valid/ready        | outcome, grant_valid, grant_id, halted,
//            |           |                    | active_count, waiting_count
//   cfg      | in        | cfg_we, no ready   | cfg_wdata = max_active
//
// Each item passes through an accept cycle, in which the wait queue reads its head
// slot into a register, and an execute cycle, in which the slot cell row runs its release
// and free-slot chains and all state is updated together with the result register.
// Reset clears the counters, the stop flags and every slot valid bit; it takes effect at once.
// A result waiting in the output register does not block the next accept; a stalled
// result only holds the following item in its execute cycle until the sink takes it.
module admission_queue_controller import aqc_pkg::*; #(
	parameter int QUEUE_DEPTH  = AQC_QUEUE_DEPTH,
	parameter int ACTIVE_SLOTS = AQC_ACTIVE_SLOTS,
	parameter int ID_BITS      = AQC_ID_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	aqc_req_if.sink          req,
	aqc_rsp_if.source        rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int IDW   = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int RUN_W = $clog2(ACTIVE_SLOTS + 1);
	localparam int CMP_W = (RUN_W > CFG_W) ? RUN_W : CFG_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     max_active_q;
	op_t                  op_q;
	logic [IDW-1:0]       id_q;
	logic [RUN_W-1:0]     running_q;
	logic                 stopping_q;
	logic                 stopped_q;

	logic                 out_valid_q;
	outcome_t             outcome_q;
	logic                 grant_valid_q;
	logic [IDW-1:0]       grant_id_q;
	logic                 halted_q;
	logic [COUNT_W-1:0]   active_count_q;
	logic [COUNT_W-1:0]   waiting_count_q;

	logic                 fire;
	logic [CNT_W-1:0]     fill;
	logic [IDW-1:0]       head_rd;
	logic [IDW-1:0]       head_id;
	logic [CMP_W-1:0]     limit;
	logic                 any_hit;
	logic                 any_free;
	slot_ctrl_t           slot_ctrl;
	slot_chain_t          chain [ACTIVE_SLOTS+1];
	logic [ACTIVE_SLOTS-1:0] slot_valid;

	// Decisions of the execute cycle.
	logic                 push;
	logic                 try_grant;
	logic                 queue_nonempty;
	logic [RUN_W-1:0]     run_base;
	logic                 grant;
	logic                 set_stopping;
	logic                 set_stopped;
	outcome_t             outcome_c;
	logic [RUN_W-1:0]     running_next;
	logic [CNT_W-1:0]     fill_next;

	// Sequencer: one item in flight, result committed when the output register is free.
	assign req.ready = (state_q == ST_IDLE);
	assign fire      = (state_q == ST_EXEC) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q <= op_t'(req.operation);
			id_q <= req.requester_id[IDW-1:0];
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_active_q <= MAX_ACTIVE_RESET;
		end else if (cfg_we) begin
			max_active_q <= cfg_wdata;
		end
	end

	// Effective run limit is the register capped at the table size.
	assign limit = (CMP_W'(max_active_q) > CMP_W'(ACTIVE_SLOTS))
		? CMP_W'(ACTIVE_SLOTS) : CMP_W'(max_active_q);

	// An execute into an empty queue is itself the head, ahead of the registered read.
	assign head_id = (fill == '0) ? id_q : head_rd;

	// Operation decode and grant decision.
	always_comb begin
		push           = 1'b0;
		try_grant      = 1'b0;
		queue_nonempty = (fill != '0);
		run_base       = running_q;
		set_stopping   = 1'b0;
		set_stopped    = 1'b0;
		slot_ctrl      = '0;
		outcome_c      = OUT_IGNORED;
		if (!stopped_q) begin
			unique case (op_q)
				OP_EXECUTE: begin
					if (stopping_q) begin
						outcome_c = OUT_REFUSED;
					end else if (fill == CNT_W'(QUEUE_DEPTH)) begin
						outcome_c = OUT_QUEUE_FULL;
						try_grant = 1'b1;
					end else begin
						push           = 1'b1;
						queue_nonempty = 1'b1;
						try_grant      = 1'b1;
						outcome_c      = OUT_QUEUED;
					end
				end
				OP_FINISH: begin
					slot_ctrl.release_en = 1'b1;
					if (running_q != '0) begin
						run_base = running_q - 1'b1;
					end
					if (stopping_q && run_base == '0) begin
						set_stopped = 1'b1;
					end else begin
						try_grant = 1'b1;
					end
				end
				OP_STOP: begin
					outcome_c    = OUT_STOP_TAKEN;
					set_stopping = 1'b1;
					set_stopped  = (running_q == '0);
				end
				default: outcome_c = OUT_IGNORED;
			endcase
		end
		grant = try_grant && queue_nonempty && (CMP_W'(run_base) < limit) && any_free;
		slot_ctrl.grant_en = grant && fire;
		slot_ctrl.release_en = slot_ctrl.release_en && fire;
		if (!stopped_q && op_q == OP_FINISH) begin
			outcome_c = any_hit ? OUT_RELEASED : OUT_UNKNOWN;
		end
		if (push && grant && fill == '0) begin
			outcome_c = OUT_GRANTED;
		end
		running_next = run_base + RUN_W'(grant);
		fill_next    = fill + CNT_W'(push) - CNT_W'(grant);
	end

	// Waiting requesters.
	aqc_wait_queue #(
		.DEPTH (QUEUE_DEPTH),
		.IDW   (IDW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push && fire),
		.push_data (id_q),
		.pop       (grant && fire),
		.fill      (fill),
		.head_data (head_rd)
	);

	// Row of active-table cells; the chains run from slot 0 upward.
	assign chain[0] = '0;

	for (genvar s = 0; s < ACTIVE_SLOTS; s++) begin : g_slot
		aqc_slot_cell #(
			.IDW (IDW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (slot_ctrl),
			.key_id    (id_q),
			.grant_id  (head_id),
			.chain_in  (chain[s]),
			.chain_out (chain[s+1]),
			.valid     (slot_valid[s])
		);
	end

	assign any_hit  = chain[ACTIVE_SLOTS].match_taken;
	assign any_free = chain[ACTIVE_SLOTS].free_taken;

	// Run counter and stop flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= '0;
			stopping_q <= 1'b0;
			stopped_q  <= 1'b0;
		end else if (fire) begin
			running_q <= running_next;
			if (set_stopping) begin
				stopping_q <= 1'b1;
			end
			if (set_stopped) begin
				stopped_q <= 1'b1;
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			outcome_q       <= outcome_c;
			grant_valid_q   <= grant;
			grant_id_q      <= grant ? head_id : '0;
			halted_q        <= stopped_q || set_stopped;
			active_count_q  <= COUNT_W'(running_next);
			waiting_count_q <= COUNT_W'(fill_next);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.outcome       = outcome_q;
	assign rsp.grant_valid   = grant_valid_q;
	assign rsp.grant_id      = ID_FIELD_W'(grant_id_q);
	assign rsp.halted        = halted_q;
	assign rsp.active_count  = active_count_q;
	assign rsp.waiting_count = waiting_count_q;

`ifndef SYNTHESIS
	// Unknown releases keep slots occupied, so occupied slots never fall below the count.
	a_slots_cover_running: assert property (@(posedge clk) disable iff (!arst_n)
		RUN_W'($countones(slot_valid)) >= running_q)
		else $error("active count exceeds occupied slots");

	// Once halted, the block stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halted flag cleared");

	// Halting is only reached through a stop request.
	a_halt_after_stop: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> stopping_q)
		else $error("halted without stop");

	// A grant never happens while the block is halted.
	a_no_grant_halted: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && stopped_q) |-> !grant)
		else $error("grant issued while halted");

	// A committed item leaves the result register valid in the next cycle.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result lost");
`endif

endmodule
